>>> sv/mlfq_pkg.sv
package mlfq_pkg;

    localparam int PID_W = 8;
    localparam int TICK_W = 16;

    typedef enum logic [2:0] {
        EV_CONT    = 3'd0,
        EV_IDLE    = 3'd1,
        EV_FINISH  = 3'd2,
        EV_IO      = 3'd3,
        EV_EXPIRE  = 3'd4,
        EV_LOAD_OK = 3'd5,
        EV_LOAD_NO = 3'd6
    } cpu_event_t;

    localparam logic [1:0] REG_QUANTUM = 2'd0;
    localparam logic [1:0] REG_DISK    = 2'd1;
    localparam logic [1:0] REG_TAPE    = 2'd2;
    localparam logic [1:0] REG_PRINTER = 2'd3;

    typedef struct packed {
        logic        action;
        logic [7:0]  pid;
        logic [15:0] arrival_tick;
        logic [7:0]  run_length;
        logic [7:0]  io_point;
        logic [1:0]  device;
    } req_t;

    typedef struct packed {
        logic [15:0] clock_value;
        logic [7:0]  ran_pid;
        logic [2:0]  cpu_event;
        logic [7:0]  disk_done_pid;
        logic [7:0]  tape_done_pid;
        logic [7:0]  printer_done_pid;
        logic        all_done;
    } rsp_t;

    typedef struct packed {
        logic start_load;
        logic start_admit;
        logic admit_step;
        logic do_select;
        logic do_run;
        logic start_io;
        logic io_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic admit_last;
        logic io_last;
    } sts_t;

endpackage

>>> sv/mlfq_ctrl.sv
module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic is_tick,
    input  logic out_busy,
    input  sts_t sts,
    output cmd_t cmd,
    output logic idle
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ADMIT  = 6'b000010,
        ST_SELECT = 6'b000100,
        ST_RUN    = 6'b001000,
        ST_IO     = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        idle = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    if (is_tick)
                    begin
                        cmd.start_admit = 1'b1;
                        state_next = ST_ADMIT;
                    end
                    else
                    begin
                        cmd.start_load = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ADMIT:
            begin
                cmd.admit_step = 1'b1;
                if (sts.admit_last)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                cmd.do_select = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.do_run = 1'b1;
                cmd.start_io = 1'b1;
                state_next = ST_IO;
            end
            ST_IO:
            begin
                cmd.io_step = 1'b1;
                if (sts.io_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/mlfq_datapath.sv
module mlfq_datapath
    import mlfq_pkg::*;
#(
    parameter int MAX_PROCS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    input  cmd_t       cmd,
    input  logic [3:0] quantum,
    input  logic [2:0] disk_time,
    input  logic [2:0] tape_time,
    input  logic [2:0] printer_time,
    output sts_t       sts,
    output rsp_t       rsp
);

    localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_PROCS);

    typedef logic [SW-1:0] slot_t;
    typedef logic [CW-1:0] cnt_t;

    // slot-indexed tables, each read at one place per step
    logic [7:0]  t_pid      [MAX_PROCS];
    logic [15:0] t_arr      [MAX_PROCS];
    logic [7:0]  t_len      [MAX_PROCS];
    logic [7:0]  t_iop      [MAX_PROCS];
    logic [1:0]  t_dev      [MAX_PROCS];
    logic [7:0]  t_done     [MAX_PROCS];
    logic [3:0]  t_slice    [MAX_PROCS];
    logic [2:0]  t_served   [MAX_PROCS];
    logic        t_fresh    [MAX_PROCS];
    logic [MAX_PROCS-1:0] used_reg;

    slot_t pq_reg [MAX_PROCS];
    slot_t hq_reg [MAX_PROCS];
    slot_t lq_reg [MAX_PROCS];
    slot_t iq_reg [MAX_PROCS];
    cnt_t  pq_cnt_reg, hq_cnt_reg, lq_cnt_reg, iq_cnt_reg;

    logic        run_valid_reg;
    slot_t       run_slot_reg;
    logic [15:0] tick_reg;

    cnt_t  idx_reg;
    cnt_t  keep_reg;
    logic [2:0] busy_reg;
    rsp_t  rsp_reg;

    // free slot search
    slot_t free_slot;
    logic  free_found;
    always_comb
    begin
        free_slot = '0;
        free_found = 1'b0;
        for (int i = MAX_PROCS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SW'(i);
                free_found = 1'b1;
            end
        end
    end

    slot_t ps, is_s, rs;
    logic  admit_hit, admit_active, io_active;
    logic [1:0] dv;
    logic [2:0] need;
    logic [2:0] srv_n;
    logic [7:0] done_n;
    logic [3:0] slice_n;

    assign admit_active = idx_reg < pq_cnt_reg;
    assign io_active = idx_reg < iq_cnt_reg;
    assign ps = pq_reg[idx_reg[SW-1:0]];
    assign is_s = iq_reg[idx_reg[SW-1:0]];
    assign admit_hit = t_arr[ps] == tick_reg;
    assign sts.admit_last = !admit_active || (idx_reg + 1'b1 >= pq_cnt_reg);
    assign sts.io_last = !io_active || (idx_reg + 1'b1 >= iq_cnt_reg);
    assign dv = (t_dev[is_s] == 2'd3) ? 2'd0 : t_dev[is_s];
    always_comb
    begin
        case (dv)
            2'd1: need = tape_time;
            2'd2: need = printer_time;
            default: need = disk_time;
        endcase
    end
    assign srv_n = t_served[is_s] + 3'd1;
    assign rs = run_slot_reg;
    assign done_n = t_done[rs] + 8'd1;
    assign slice_n = t_slice[rs] + 4'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.start_load && free_found)
        begin
            t_pid[free_slot] <= req.pid;
            t_arr[free_slot] <= req.arrival_tick;
            t_len[free_slot] <= req.run_length;
            t_iop[free_slot] <= req.io_point;
            t_dev[free_slot] <= req.device;
            t_done[free_slot] <= '0;
            t_slice[free_slot] <= '0;
            t_served[free_slot] <= '0;
            t_fresh[free_slot] <= 1'b0;
        end
        if (cmd.do_run && run_valid_reg)
        begin
            t_done[rs] <= done_n;
            if (done_n == t_len[rs])
            begin
                t_slice[rs] <= slice_n;
            end
            else if (t_iop[rs] != 8'd0 && done_n == t_iop[rs])
            begin
                t_fresh[rs] <= 1'b1;
                t_slice[rs] <= '0;
                t_served[rs] <= '0;
            end
            else if (slice_n == quantum)
            begin
                t_slice[rs] <= '0;
            end
            else
            begin
                t_slice[rs] <= slice_n;
            end
        end
        if (cmd.io_step && io_active)
        begin
            if (t_fresh[is_s])
            begin
                t_fresh[is_s] <= 1'b0;
            end
            else if (!busy_reg[dv])
            begin
                t_served[is_s] <= srv_n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            pq_cnt_reg <= '0;
            hq_cnt_reg <= '0;
            lq_cnt_reg <= '0;
            iq_cnt_reg <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg <= '0;
            tick_reg <= '0;
            idx_reg <= '0;
            keep_reg <= '0;
            busy_reg <= '0;
            rsp_reg <= '0;
        end
        else
        begin
            if (cmd.start_load)
            begin
                rsp_reg <= '{clock_value: tick_reg,
                             cpu_event: free_found ? EV_LOAD_OK : EV_LOAD_NO,
                             default: '0};
                if (free_found)
                begin
                    used_reg[free_slot] <= 1'b1;
                    pq_reg[pq_cnt_reg[SW-1:0]] <= free_slot;
                    pq_cnt_reg <= pq_cnt_reg + 1'b1;
                end
            end
            if (cmd.start_admit)
            begin
                idx_reg <= '0;
                keep_reg <= '0;
                rsp_reg <= '{clock_value: tick_reg, default: '0};
            end
            if (cmd.admit_step)
            begin
                if (admit_active)
                begin
                    if (admit_hit)
                    begin
                        if (hq_cnt_reg < FULL)
                        begin
                            hq_reg[hq_cnt_reg[SW-1:0]] <= ps;
                            hq_cnt_reg <= hq_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pq_reg[keep_reg[SW-1:0]] <= ps;
                        keep_reg <= keep_reg + 1'b1;
                    end
                end
                if (sts.admit_last)
                begin
                    pq_cnt_reg <= (admit_active && !admit_hit) ? keep_reg + 1'b1
                                                                : keep_reg;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.do_select && !run_valid_reg)
            begin
                if (hq_cnt_reg != '0)
                begin
                    run_slot_reg <= hq_reg[0];
                    run_valid_reg <= 1'b1;
                    for (int i = 1; i < MAX_PROCS; i++)
                    begin
                        hq_reg[i-1] <= hq_reg[i];
                    end
                    hq_cnt_reg <= hq_cnt_reg - 1'b1;
                end
                else if (lq_cnt_reg != '0)
                begin
                    run_slot_reg <= lq_reg[0];
                    run_valid_reg <= 1'b1;
                    for (int i = 1; i < MAX_PROCS; i++)
                    begin
                        lq_reg[i-1] <= lq_reg[i];
                    end
                    lq_cnt_reg <= lq_cnt_reg - 1'b1;
                end
            end
            if (cmd.do_run)
            begin
                if (run_valid_reg)
                begin
                    rsp_reg.ran_pid <= t_pid[rs];
                    if (done_n == t_len[rs])
                    begin
                        used_reg[rs] <= 1'b0;
                        run_valid_reg <= 1'b0;
                        rsp_reg.cpu_event <= EV_FINISH;
                    end
                    else if (t_iop[rs] != 8'd0 && done_n == t_iop[rs])
                    begin
                        if (iq_cnt_reg < FULL)
                        begin
                            iq_reg[iq_cnt_reg[SW-1:0]] <= rs;
                            iq_cnt_reg <= iq_cnt_reg + 1'b1;
                        end
                        run_valid_reg <= 1'b0;
                        rsp_reg.cpu_event <= EV_IO;
                    end
                    else if (slice_n == quantum)
                    begin
                        if (lq_cnt_reg < FULL)
                        begin
                            lq_reg[lq_cnt_reg[SW-1:0]] <= rs;
                            lq_cnt_reg <= lq_cnt_reg + 1'b1;
                        end
                        run_valid_reg <= 1'b0;
                        rsp_reg.cpu_event <= EV_EXPIRE;
                    end
                    else
                    begin
                        rsp_reg.cpu_event <= EV_CONT;
                    end
                end
                else
                begin
                    rsp_reg.cpu_event <= EV_IDLE;
                end
            end
            if (cmd.start_io)
            begin
                idx_reg <= '0;
                keep_reg <= '0;
                busy_reg <= '0;
            end
            if (cmd.io_step)
            begin
                logic leave;
                leave = io_active && !t_fresh[is_s] && !busy_reg[dv] && srv_n == need;
                if (io_active)
                begin
                    if (!t_fresh[is_s] && !busy_reg[dv])
                    begin
                        busy_reg[dv] <= 1'b1;
                    end
                    if (leave)
                    begin
                        case (dv)
                            2'd1: rsp_reg.tape_done_pid <= t_pid[is_s];
                            2'd2: rsp_reg.printer_done_pid <= t_pid[is_s];
                            default: rsp_reg.disk_done_pid <= t_pid[is_s];
                        endcase
                        if (dv == 2'd0)
                        begin
                            if (lq_cnt_reg < FULL)
                            begin
                                lq_reg[lq_cnt_reg[SW-1:0]] <= is_s;
                                lq_cnt_reg <= lq_cnt_reg + 1'b1;
                            end
                        end
                        else if (hq_cnt_reg < FULL)
                        begin
                            hq_reg[hq_cnt_reg[SW-1:0]] <= is_s;
                            hq_cnt_reg <= hq_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        iq_reg[keep_reg[SW-1:0]] <= is_s;
                        keep_reg <= keep_reg + 1'b1;
                    end
                end
                if (sts.io_last)
                begin
                    iq_cnt_reg <= (io_active && !leave) ? keep_reg + 1'b1 : keep_reg;
                    tick_reg <= tick_reg + 16'd1;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        rsp = rsp_reg;
        rsp.all_done = (pq_cnt_reg == '0) && (hq_cnt_reg == '0) &&
                       (lq_cnt_reg == '0) && (iq_cnt_reg == '0) && !run_valid_reg;
    end

endmodule

>>> sv/mlfq_scheduler_tick_unit.sv
// Two-level feedback queue scheduler, one clock tick or one process load per
// request.
// Input channel in_valid/in_ready carries a req_t: action 0 loads a process
// into the pending table, action 1 advances the scheduler by one tick.
// Output channel out_valid/out_ready carries one rsp_t per request.
// Registers quantum, disk_time, tape_time, printer_time sit on the APB port
// at byte addresses 0, 4, 8, 12; write them only while the block is idle.
// A load goes from idle straight to the done state. A tick runs the admit
// loop over the pending queue, a select step, a run step and the I/O service
// loop over the I/O queue; both loops visit one queue entry per cycle.
// One request is in flight at a time; the result sits in an output register
// and the next request is taken once that result has been consumed.
// Reset empties all queues, clears the clock, stops the CPU and restores
// the register defaults. A stalled receiver holds the result and the
// block accepts nothing new until it is taken.
module mlfq_scheduler_tick_unit
    import mlfq_pkg::*;
#(
    parameter int MAX_PROCS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rsp_t        out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] quantum_reg;
    logic [2:0] disk_reg, tape_reg, printer_reg;
    req_t req_reg;
    cmd_t cmd;
    sts_t sts;
    rsp_t rsp;
    logic idle, out_valid_reg, in_fire;

    assign pready = 1'b1;
    assign in_ready = idle && !out_valid_reg;
    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= 4'd4;
            disk_reg <= 3'd2;
            tape_reg <= 3'd4;
            printer_reg <= 3'd5;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_QUANTUM: quantum_reg <= pwdata[3:0];
                REG_DISK:    disk_reg <= pwdata[2:0];
                REG_TAPE:    tape_reg <= pwdata[2:0];
                REG_PRINTER: printer_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_QUANTUM: prdata = {28'd0, quantum_reg};
            REG_DISK:    prdata = {29'd0, disk_reg};
            REG_TAPE:    prdata = {29'd0, tape_reg};
            REG_PRINTER: prdata = {29'd0, printer_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    mlfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .is_tick  (in_data.action),
        .out_busy (out_valid_reg),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle)
    );

    mlfq_datapath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (in_fire ? in_data : req_reg),
        .cmd          (cmd),
        .quantum      (quantum_reg),
        .disk_time    (disk_reg),
        .tape_time    (tape_reg),
        .printer_time (printer_reg),
        .sts          (sts),
        .rsp          (rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_data = rsp;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_fire)
        else $error("request accepted while result pending");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_valid_reg)
        else $error("result overwritten");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("result not presented");
`endif

endmodule
